@@ src/acmt_pkg.sv @@
// ----------------------------------------------------------------------------
// acmt_pkg: shared types, constants and AES round functions
// Blocks are 16 bytes, byte i in bits 8i+7:8i.
// ----------------------------------------------------------------------------
package acmt_pkg;

    typedef logic [127:0] t_blk;

    // configuration register indexes
    localparam logic [7:0] CFG_KEY_LO  = 8'd0;
    localparam logic [7:0] CFG_KEY_HI  = 8'd1;
    localparam logic [7:0] CFG_COUNTER = 8'd2;
    localparam logic [7:0] CFG_LENGTH  = 8'd3;

    localparam int unsigned AES_ROUNDS = 10;

    // work for the cipher engine: optional block a, optional block b, then an optional tag
    typedef struct packed {
        logic use_a;
        logic use_b;
        logic emit;
        t_blk a;
        t_blk b;
    } t_cmd;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes followed by ShiftRows
    function automatic t_blk sub_shift(input t_blk s);
        t_blk t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[8*(r+4*c) +: 8] = SBOX[s[8*(r+4*((c+r)%4)) +: 8]];
            end
        end
        return t;
    endfunction

    function automatic t_blk mix_columns(input t_blk t);
        t_blk m;
        logic [7:0] a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++) begin
            a0  = t[32*c +: 8];
            a1  = t[32*c+8 +: 8];
            a2  = t[32*c+16 +: 8];
            a3  = t[32*c+24 +: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            m[32*c +: 8]    = a0 ^ all ^ xtime(a0 ^ a1);
            m[32*c+8 +: 8]  = a1 ^ all ^ xtime(a1 ^ a2);
            m[32*c+16 +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            m[32*c+24 +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return m;
    endfunction

    // next AES-128 round key
    function automatic t_blk key_step(input t_blk rk, input logic [7:0] rcon);
        logic [31:0] tmp, w0, w1, w2, w3;
        tmp = {SBOX[rk[103:96]], SBOX[rk[127:120]], SBOX[rk[119:112]],
               SBOX[rk[111:104]] ^ rcon};
        w0  = rk[31:0] ^ tmp;
        w1  = rk[63:32] ^ w0;
        w2  = rk[95:64] ^ w1;
        w3  = rk[127:96] ^ w2;
        return {w3, w2, w1, w0};
    endfunction

endpackage

@@ src/aes_chained_message_tag.sv @@
// ----------------------------------------------------------------------------
// aes_chained_message_tag: 96-bit tag from an AES-128 chain keyed by blocks
// Each AES block takes a load step and ten rounds in the engine; a one-word
//   message runs two blocks before its tag shows. Message words are paired,
//   one AES block per two words; the single iterative round unit takes a new
//   command only once its current blocks are done.
// Reset: synchronous, clears configuration to defaults and all chain state.
// ----------------------------------------------------------------------------
module aes_chained_message_tag #(
    parameter int LENGTH_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // [63:0] data_word
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata    // [63:0] tag_first8, [95:64] tag_last4
);

    logic           push, pop, full, empty;
    acmt_pkg::t_cmd cmd_in, cmd_out;

    assign o_cfg_ready = 1'b1;

    acmt_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data_word (i_s_axis_tdata),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .i_full      (full)
    );

    acmt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (cmd_out)
    );

    acmt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (cmd_out),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_tag   (o_m_axis_tdata)
    );

endmodule

@@ src/acmt_front.sv @@
// ----------------------------------------------------------------------------
// acmt_front: configuration registers and message word classification
// Masks bytes past the length, pairs words into blocks and queues cipher work.
// ----------------------------------------------------------------------------
module acmt_front #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [7:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [63:0]         i_data_word,
    output logic                o_push,
    output acmt_pkg::t_cmd      o_cmd,
    input  logic                i_full
);

    logic [63:0]            r_key_lo, r_key_hi;
    logic [31:0]            r_counter;
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] r_consumed, n_consumed;
    logic [63:0]            r_held, n_held;
    logic                   r_pending, n_pending;
    logic                   r_started, n_started;

    logic                   accept, done_before, done;
    logic [LENGTH_BITS-1:0] remain;
    logic [3:0]             nbytes;
    logic [63:0]            word;
    acmt_pkg::t_cmd         cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        remain = (r_consumed < r_len) ? r_len - r_consumed : '0;
        nbytes = (remain > LENGTH_BITS'(8)) ? 4'd8 : remain[3:0];
        for (int j = 0; j < 8; j++) begin
            word[8*j +: 8] = (4'(j) < nbytes) ? i_data_word[8*j +: 8] : 8'h00;
        end
    end

    always_comb begin
        done_before = r_started && (r_consumed >= r_len);
        n_consumed  = r_consumed;
        n_held      = r_held;
        n_pending   = r_pending;
        n_started   = r_started;
        cmd         = '0;
        if (!done_before) begin
            n_consumed = r_consumed + LENGTH_BITS'(nbytes);
            if (!r_started) begin
                cmd.use_a = 1'b1;
                cmd.a     = {r_key_hi, r_key_lo};
                cmd.use_b = 1'b1;
                cmd.b     = {word, 32'(r_len), r_counter};
                n_started = 1'b1;
            end else if (!r_pending) begin
                n_held    = word;
                n_pending = 1'b1;
                cmd.b     = {64'h0, word};
            end else begin
                cmd.use_b = 1'b1;
                cmd.b     = {word, r_held};
                n_pending = 1'b0;
            end
        end else begin
            cmd.b = {64'h0, r_held};
        end
        done = n_consumed >= r_len;
        // a half block still held at the end is flushed with zero padding
        if (done && n_pending) begin
            cmd.use_b = 1'b1;
        end
        cmd.emit = done;
        if (done) begin
            n_consumed = '0;
            n_held     = '0;
            n_pending  = 1'b0;
            n_started  = 1'b0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.use_a || cmd.use_b || cmd.emit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo   <= '0;
            r_key_hi   <= '0;
            r_counter  <= '0;
            r_len      <= LENGTH_BITS'(1);
            r_consumed <= '0;
            r_held     <= '0;
            r_pending  <= 1'b0;
            r_started  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    acmt_pkg::CFG_KEY_LO:  r_key_lo  <= i_cfg_data;
                    acmt_pkg::CFG_KEY_HI:  r_key_hi  <= i_cfg_data;
                    acmt_pkg::CFG_COUNTER: r_counter <= i_cfg_data[31:0];
                    acmt_pkg::CFG_LENGTH:  r_len     <= i_cfg_data[LENGTH_BITS-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_consumed <= n_consumed;
                r_held     <= n_held;
                r_pending  <= n_pending;
                r_started  <= n_started;
            end
        end
    end

endmodule

@@ src/acmt_fifo.sv @@
// ----------------------------------------------------------------------------
// acmt_fifo: two-entry command queue
// Decouples word classification from the cipher engine.
// ----------------------------------------------------------------------------
module acmt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  acmt_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output acmt_pkg::t_cmd o_cmd
);

    acmt_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

@@ src/acmt_back.sv @@
// ----------------------------------------------------------------------------
// acmt_back: iterative AES-128 chaining engine and tag output register
// One round per cycle unless the tag is unread; round key expanded on the fly.
// ----------------------------------------------------------------------------
module acmt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  acmt_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [95:0]    o_tag
);

    acmt_pkg::t_blk r_chain, r_s, r_rk, r_b;
    logic [3:0]     r_round;
    logic [7:0]     r_rcon;
    logic           r_busy, r_second, r_emit;
    logic           r_out_valid;
    logic [95:0]    r_tag;

    acmt_pkg::t_blk sub, mixed, rk_next, res;
    logic           last, out_free, tag_load;

    assign last     = r_round == 4'(acmt_pkg::AES_ROUNDS);
    assign out_free = !r_out_valid || i_ready;
    assign sub      = acmt_pkg::sub_shift(r_s);
    assign mixed    = last ? sub : acmt_pkg::mix_columns(sub);
    assign rk_next  = acmt_pkg::key_step(r_rk, r_rcon);
    assign res      = mixed ^ rk_next;

    // an emit-only command needs the output register at once
    assign o_pop   = !r_busy && !i_empty &&
                     (i_cmd.use_a || i_cmd.use_b || out_free);
    assign o_valid = r_out_valid;
    assign o_tag   = r_tag;

    assign tag_load = (o_pop && !i_cmd.use_a && !i_cmd.use_b) ||
                      (r_busy && last && !r_second && r_emit && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain     <= '0;
            r_busy      <= 1'b0;
            r_second    <= 1'b0;
            r_emit      <= 1'b0;
            r_round     <= '0;
            r_rcon      <= 8'h01;
            r_out_valid <= 1'b0;
        end else begin
            if (tag_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_emit  <= i_cmd.emit;
                r_b     <= i_cmd.b;
                r_round <= 4'd1;
                r_rcon  <= 8'h01;
                if (i_cmd.use_a) begin
                    r_busy   <= 1'b1;
                    r_second <= i_cmd.use_b;
                    r_s      <= r_chain ^ i_cmd.a;
                    r_rk     <= i_cmd.a;
                end else if (i_cmd.use_b) begin
                    r_busy   <= 1'b1;
                    r_second <= 1'b0;
                    r_s      <= r_chain ^ i_cmd.b;
                    r_rk     <= i_cmd.b;
                end else begin
                    r_tag   <= r_chain[95:0];
                    r_chain <= '0;
                end
            end else if (r_busy) begin
                if (!last) begin
                    r_s     <= res;
                    r_rk    <= rk_next;
                    r_rcon  <= acmt_pkg::xtime(r_rcon);
                    r_round <= r_round + 4'd1;
                end else if (r_second) begin
                    r_chain  <= res;
                    r_s      <= res ^ r_b;
                    r_rk     <= r_b;
                    r_rcon   <= 8'h01;
                    r_round  <= 4'd1;
                    r_second <= 1'b0;
                end else if (r_emit) begin
                    // hold in the final round until the tag can be written
                    if (out_free) begin
                        r_tag   <= res[95:0];
                        r_chain <= '0;
                        r_busy  <= 1'b0;
                    end
                end else begin
                    r_chain <= res;
                    r_busy  <= 1'b0;
                end
            end
        end
    end

endmodule
